// File: hw/rtl/rmms_pkg.sv
// Shared widths, types and the sample helper function of the raster statistics block.
package rmms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;

  localparam int IN_W     = 16;
  localparam int MINMAX_W = 16;
  localparam int MEAN_W   = 24;
  localparam int SD_W     = 24;
  localparam int VCNT_W   = 25;

  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int MAG_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam int NUM_W  = PROD_W + 16;
  localparam int NUM_X  = (NUM_W > 64) ? NUM_W : 65;
  localparam int DVS_W  = 2 * CNT_W;
  localparam int ITER_W = $clog2(NUM_W + 1);
  localparam int ROOT_STEPS = 32;

  localparam int SNAP_DEPTH = 2;
  localparam int PTR_W = (SNAP_DEPTH > 1) ? $clog2(SNAP_DEPTH) : 1;
  localparam int LVL_W = $clog2(SNAP_DEPTH + 1);

  localparam logic [NUM_W-1:0] MEAN_POS_LIMIT = NUM_W'((1 << (MEAN_W - 1)) - 1);
  localparam logic [NUM_W-1:0] MEAN_NEG_LIMIT = NUM_W'(1 << (MEAN_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] min_val;
    logic signed [SAMPLE_BITS-1:0] max_val;
    logic signed [SUM_W-1:0]       sum_val;
    logic [SQ_W-1:0]               sum_sq;
    logic [CNT_W-1:0]              count;
  } snap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIFF,
    ST_DIV_VAR,
    ST_DIV_MEAN,
    ST_SQRT,
    ST_DONE
  } back_state_e;

  // Bits of the port beyond the sample width are dropped; missing bits read as zero.
  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic [IN_W-1:0] raw);
    logic [SAMPLE_BITS-1:0] r;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      r[i] = (i < IN_W) ? raw[i] : 1'b0;
    end
    return $signed(r);
  endfunction

endpackage

// File: hw/rtl/rmms_front.sv
// Front end: accepts cells, squares them and keeps the running statistics.
module rmms_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [rmms_pkg::IN_W-1:0]    sample_i,
  input  logic                                no_data_i,
  input  logic                                last_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [rmms_pkg::LVL_W-1:0]          fifo_level_i,
  output logic                                snap_push_o,
  output rmms_pkg::snap_t                     snap_o
);

  localparam int SB = rmms_pkg::SAMPLE_BITS;

  logic                          accept;
  logic signed [SB-1:0]          sample_ext;
  logic [SB-1:0]                 mag;
  logic [rmms_pkg::LVL_W:0]      pending;

  logic                          s1_valid_q, s1_valid_d;
  logic                          s1_last_q;
  logic                          s1_use_q;
  logic signed [SB-1:0]          s1_sample_q;
  logic [2*SB-1:0]               s1_sq_q;

  logic signed [SB-1:0]                   min_q, min_d;
  logic signed [SB-1:0]                   max_q, max_d;
  logic signed [rmms_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [rmms_pkg::SQ_W-1:0]              sq_q, sq_d;
  logic [rmms_pkg::CNT_W-1:0]             cnt_q, cnt_d;
  logic                                   take;

  // A raster end waiting in the first stage already owns a queue slot.
  assign pending = {1'b0, fifo_level_i} + (rmms_pkg::LVL_W + 1)'(s1_valid_q && s1_last_q);
  assign full_o  = pending >= (rmms_pkg::LVL_W + 1)'(rmms_pkg::SNAP_DEPTH);
  assign accept  = push_i && !full_o;

  assign sample_ext = rmms_pkg::to_sample(sample_i);
  assign mag        = sample_ext[SB-1] ? SB'(-sample_ext) : sample_ext;
  assign s1_valid_d = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q   <= last_i;
      s1_use_q    <= !no_data_i;
      s1_sample_q <= sample_ext;
      s1_sq_q     <= mag * mag;
    end
  end

  assign take = s1_valid_q && s1_use_q && !cnt_q[rmms_pkg::COUNT_BITS];

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    cnt_d = cnt_q;
    if (take) begin
      if (cnt_q == '0 || s1_sample_q < min_q) begin
        min_d = s1_sample_q;
      end
      if (cnt_q == '0 || s1_sample_q > max_q) begin
        max_d = s1_sample_q;
      end
      sum_d = sum_q + rmms_pkg::SUM_W'(s1_sample_q);
      sq_d  = sq_q + rmms_pkg::SQ_W'(s1_sq_q);
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign snap_push_o    = s1_valid_q && s1_last_q;
  assign snap_o.min_val = min_d;
  assign snap_o.max_val = max_d;
  assign snap_o.sum_val = sum_d;
  assign snap_o.sum_sq  = sq_d;
  assign snap_o.count   = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
    end else if (snap_push_o) begin
      min_q <= '0;
      max_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      sum_q <= sum_d;
      sq_q  <= sq_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/rmms_snap_fifo.sv
// Short queue of finished raster totals between the front and back ends.
module rmms_snap_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  rmms_pkg::snap_t             data_i,
  input  logic                        pop_i,
  output rmms_pkg::snap_t             data_o,
  output logic                        empty_o,
  output logic [rmms_pkg::LVL_W-1:0]  level_o
);

  localparam int PW = rmms_pkg::PTR_W;

  rmms_pkg::snap_t               slot_q [rmms_pkg::SNAP_DEPTH];
  logic [PW-1:0]                 wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [rmms_pkg::LVL_W-1:0]    level_q, level_d;
  logic                          do_pop;

  assign empty_o = (level_q == '0);
  assign level_o = level_q;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(rmms_pkg::SNAP_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(rmms_pkg::SNAP_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/rmms_back.sv
// Back end: serial multiply, divide and square root that finish one raster.
module rmms_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rmms_pkg::snap_t                      snap_i,
  input  logic                                 snap_empty_i,
  output logic                                 snap_pop_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic signed [rmms_pkg::MINMAX_W-1:0] min_out_o,
  output logic signed [rmms_pkg::MINMAX_W-1:0] max_out_o,
  output logic signed [rmms_pkg::MEAN_W-1:0]   mean_out_o,
  output logic [rmms_pkg::SD_W-1:0]            std_dev_out_o,
  output logic [rmms_pkg::VCNT_W-1:0]          valid_count_o,
  output logic                                 empty_res_o
);

  localparam int PROD_W = rmms_pkg::PROD_W;
  localparam int MAG_W  = rmms_pkg::MAG_W;
  localparam int NUM_W  = rmms_pkg::NUM_W;
  localparam int DVS_W  = rmms_pkg::DVS_W;
  localparam int ITER_W = rmms_pkg::ITER_W;
  localparam int SUM_W  = rmms_pkg::SUM_W;

  rmms_pkg::back_state_e state_q, state_d;

  rmms_pkg::snap_t             snap_q, snap_d;
  logic                        neg_q, neg_d;
  logic [PROD_W-1:0]           a_q, a_d;
  logic [PROD_W-1:0]           prod_q, prod_d;
  logic [PROD_W-1:0]           mcand_q, mcand_d;
  logic [MAG_W-1:0]            mplier_q, mplier_d;
  logic [DVS_W-1:0]            c2_q, c2_d;
  logic [DVS_W-1:0]            rem_q, rem_d;
  logic [NUM_W-1:0]            quo_q, quo_d;
  logic [63:0]                 var_q, var_d;
  logic [rmms_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic [63:0]                 rt_v_q, rt_v_d;
  logic [63:0]                 rt_res_q, rt_res_d;
  logic [63:0]                 rt_bit_q, rt_bit_d;
  logic [ITER_W-1:0]           cnt_q, cnt_d;

  logic                        res_valid_q, res_valid_d;
  logic                        res_load;
  logic                        step_last;

  logic [PROD_W-1:0]           mul_sum;
  logic [SUM_W-1:0]            sum_neg;
  logic [MAG_W-1:0]            mag;
  logic [DVS_W-1:0]            dvs;
  logic [DVS_W:0]              div_sh;
  logic [DVS_W:0]              div_sub;
  logic                        div_ge;
  logic [DVS_W-1:0]            rem_next;
  logic [NUM_W-1:0]            quo_next;
  logic [rmms_pkg::NUM_X-1:0]  quo_ext;
  logic [PROD_W-1:0]           diff;
  logic [63:0]                 rt_try;
  logic                        rt_ge;
  logic [rmms_pkg::SD_W-1:0]   sd_sat;

  assign step_last = (cnt_q == ITER_W'(1));
  assign empty_o   = !res_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmms_pkg::ST_IDLE: begin
        if (!snap_empty_i) begin
          state_d = (snap_i.count == '0) ? rmms_pkg::ST_DONE : rmms_pkg::ST_MUL_A;
        end
      end
      rmms_pkg::ST_MUL_A:    if (step_last) state_d = rmms_pkg::ST_MUL_B;
      rmms_pkg::ST_MUL_B:    if (step_last) state_d = rmms_pkg::ST_DIFF;
      rmms_pkg::ST_DIFF:     state_d = rmms_pkg::ST_DIV_VAR;
      rmms_pkg::ST_DIV_VAR:  if (step_last) state_d = rmms_pkg::ST_DIV_MEAN;
      rmms_pkg::ST_DIV_MEAN: if (step_last) state_d = rmms_pkg::ST_SQRT;
      rmms_pkg::ST_SQRT:     if (step_last) state_d = rmms_pkg::ST_DONE;
      rmms_pkg::ST_DONE:     if (res_load) state_d = rmms_pkg::ST_IDLE;
      default:               state_d = rmms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    snap_pop_o = (state_q == rmms_pkg::ST_IDLE) && !snap_empty_i;
    res_load   = (state_q == rmms_pkg::ST_DONE) && (!res_valid_q || pop_i);
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmms_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign mul_sum  = prod_q + (mplier_q[0] ? mcand_q : '0);
  assign sum_neg  = -snap_q.sum_val;
  assign mag      = snap_q.sum_val[SUM_W-1] ? MAG_W'(sum_neg) : MAG_W'(snap_q.sum_val);
  assign dvs      = (state_q == rmms_pkg::ST_DIV_VAR) ? c2_q : DVS_W'(snap_q.count);
  assign div_sh   = {rem_q, quo_q[NUM_W-1]};
  assign div_ge   = div_sh >= {1'b0, dvs};
  assign div_sub  = div_sh - {1'b0, dvs};
  assign rem_next = div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
  assign quo_next = {quo_q[NUM_W-2:0], div_ge};
  assign quo_ext  = rmms_pkg::NUM_X'(quo_next);
  assign diff     = (a_q >= prod_q) ? a_q - prod_q : '0;
  assign rt_try   = rt_res_q + rt_bit_q;
  assign rt_ge    = rt_v_q >= rt_try;
  assign sd_sat   = (rt_res_q[63:rmms_pkg::SD_W] != '0) ? '1 : rt_res_q[rmms_pkg::SD_W-1:0];

  always_comb begin
    snap_d   = snap_q;
    neg_d    = neg_q;
    a_d      = a_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    c2_d     = c2_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    var_d    = var_q;
    mean_d   = mean_q;
    rt_v_d   = rt_v_q;
    rt_res_d = rt_res_q;
    rt_bit_d = rt_bit_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      rmms_pkg::ST_IDLE: begin
        if (!snap_empty_i) begin
          snap_d   = snap_i;
          prod_d   = '0;
          mcand_d  = PROD_W'(snap_i.sum_sq);
          mplier_d = MAG_W'(snap_i.count);
          cnt_d    = ITER_W'(rmms_pkg::CNT_W);
        end
      end
      rmms_pkg::ST_MUL_A, rmms_pkg::ST_MUL_B: begin
        prod_d   = mul_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (step_last && state_q == rmms_pkg::ST_MUL_A) begin
          a_d      = mul_sum;
          prod_d   = '0;
          mcand_d  = PROD_W'(mag);
          mplier_d = mag;
          neg_d    = snap_q.sum_val[SUM_W-1];
          cnt_d    = ITER_W'(MAG_W);
        end
      end
      rmms_pkg::ST_DIFF: begin
        quo_d = NUM_W'(diff) << 16;
        rem_d = '0;
        c2_d  = snap_q.count * snap_q.count;
        cnt_d = ITER_W'(NUM_W);
      end
      rmms_pkg::ST_DIV_VAR, rmms_pkg::ST_DIV_MEAN: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q - 1'b1;
        if (step_last && state_q == rmms_pkg::ST_DIV_VAR) begin
          var_d = (quo_ext[rmms_pkg::NUM_X-1:64] != '0) ? '1 : quo_ext[63:0];
          rem_d = '0;
          quo_d = NUM_W'(mag) << 8;
          cnt_d = ITER_W'(NUM_W);
        end
        if (step_last && state_q == rmms_pkg::ST_DIV_MEAN) begin
          if (neg_q) begin
            mean_d = (quo_next > rmms_pkg::MEAN_NEG_LIMIT) ?
                     rmms_pkg::MEAN_NEG_LIMIT[rmms_pkg::MEAN_W-1:0] :
                     -quo_next[rmms_pkg::MEAN_W-1:0];
          end else begin
            mean_d = (quo_next > rmms_pkg::MEAN_POS_LIMIT) ?
                     rmms_pkg::MEAN_POS_LIMIT[rmms_pkg::MEAN_W-1:0] :
                     quo_next[rmms_pkg::MEAN_W-1:0];
          end
          rt_v_d   = var_q;
          rt_res_d = '0;
          rt_bit_d = 64'h4000_0000_0000_0000;
          cnt_d    = ITER_W'(rmms_pkg::ROOT_STEPS);
        end
      end
      rmms_pkg::ST_SQRT: begin
        if (rt_ge) begin
          rt_v_d   = rt_v_q - rt_try;
          rt_res_d = (rt_res_q >> 1) + rt_bit_q;
        end else begin
          rt_res_d = rt_res_q >> 1;
        end
        rt_bit_d = rt_bit_q >> 2;
        cnt_d    = cnt_q - 1'b1;
      end
      rmms_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    snap_q   <= snap_d;
    neg_q    <= neg_d;
    a_q      <= a_d;
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    c2_q     <= c2_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    var_q    <= var_d;
    mean_q   <= mean_d;
    rt_v_q   <= rt_v_d;
    rt_res_q <= rt_res_d;
    rt_bit_q <= rt_bit_d;
    cnt_q    <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (snap_q.count == '0) begin
        min_out_o     <= '0;
        max_out_o     <= '0;
        mean_out_o    <= '0;
        std_dev_out_o <= '0;
        valid_count_o <= '0;
        empty_res_o   <= 1'b1;
      end else begin
        min_out_o     <= rmms_pkg::MINMAX_W'(snap_q.min_val);
        max_out_o     <= rmms_pkg::MINMAX_W'(snap_q.max_val);
        mean_out_o    <= mean_q;
        std_dev_out_o <= sd_sat;
        valid_count_o <= rmms_pkg::VCNT_W'(snap_q.count);
        empty_res_o   <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/raster_min_max_mean_stddev.sv
// Throughput: one cell per cycle; cells stall only while two finished rasters hold queue slots,
// counting one whose last cell waits in the first front stage. After its last cell, a raster's
// totals pass that stage and the queue; the back end then runs its serial multiply, divide and root.
// An empty raster skips the multiply, divide and root and goes straight to the result load.
// Reset clears the running totals, the queue and the result beat; no clearing pass is needed.
// Top level of the raster minimum, maximum, mean and standard deviation block.
module raster_min_max_mean_stddev (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [rmms_pkg::IN_W-1:0]     sample_i,
  input  logic                                 no_data_i,
  input  logic                                 last_i,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic signed [rmms_pkg::MINMAX_W-1:0] min_out_o,
  output logic signed [rmms_pkg::MINMAX_W-1:0] max_out_o,
  output logic signed [rmms_pkg::MEAN_W-1:0]   mean_out_o,
  output logic [rmms_pkg::SD_W-1:0]            std_dev_out_o,
  output logic [rmms_pkg::VCNT_W-1:0]          valid_count_o,
  output logic                                 empty_res_o
);

  logic                        snap_push;
  rmms_pkg::snap_t             snap_in;
  rmms_pkg::snap_t             snap_out;
  logic                        snap_empty;
  logic                        snap_pop;
  logic [rmms_pkg::LVL_W-1:0]  snap_level;

  rmms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .no_data_i    (no_data_i),
    .last_i       (last_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .fifo_level_i (snap_level),
    .snap_push_o  (snap_push),
    .snap_o       (snap_in)
  );

  rmms_snap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .pop_i   (snap_pop),
    .data_o  (snap_out),
    .empty_o (snap_empty),
    .level_o (snap_level)
  );

  rmms_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_i        (snap_out),
    .snap_empty_i  (snap_empty),
    .snap_pop_o    (snap_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .min_out_o     (min_out_o),
    .max_out_o     (max_out_o),
    .mean_out_o    (mean_out_o),
    .std_dev_out_o (std_dev_out_o),
    .valid_count_o (valid_count_o),
    .empty_res_o   (empty_res_o)
  );

endmodule

// File: hw/rtl/rmms_checker.sv
// Port-level assertions for the raster statistics block and their bind.
module rmms_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 pop_i,
  input logic                                 empty_o,
  input logic signed [rmms_pkg::MINMAX_W-1:0] min_out_o,
  input logic signed [rmms_pkg::MINMAX_W-1:0] max_out_o,
  input logic signed [rmms_pkg::MEAN_W-1:0]   mean_out_o,
  input logic [rmms_pkg::SD_W-1:0]            std_dev_out_o,
  input logic [rmms_pkg::VCNT_W-1:0]          valid_count_o,
  input logic                                 empty_res_o
);

  // A result beat that is not taken keeps its mean, deviation, count and empty flag unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(mean_out_o) && $stable(std_dev_out_o)
      && $stable(valid_count_o) && $stable(empty_res_o))
    else $error("result beat changed while stalled");

  // An empty raster reports all statistics as zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && empty_res_o |-> min_out_o == '0 && max_out_o == '0 && mean_out_o == '0
      && std_dev_out_o == '0 && valid_count_o == '0)
    else $error("empty raster with nonzero statistics");

  // A raster with valid cells has a count and an ordered range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !empty_res_o |-> valid_count_o != '0 && min_out_o <= max_out_o)
    else $error("nonempty raster with bad count or range");

  // Equal extremes mean every cell was equal, so the deviation is zero.
  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !empty_res_o && min_out_o == max_out_o |-> std_dev_out_o == '0)
    else $error("flat raster with nonzero deviation");

endmodule

bind raster_min_max_mean_stddev rmms_checker u_rmms_checker (.*);
